@@ sv/tgc_pkg.sv @@
// tgc_pkg: shared widths, payload structs and state encodings for the
// totient-by-gcd-count block. No dependencies.
package tgc_pkg;

	localparam int NUMBER_WIDTH = 16;
	localparam int TOTAL_WIDTH  = 48;
	// step counter of the remainder unit must hold NUMBER_WIDTH itself
	localparam int STEP_WIDTH   = $clog2(NUMBER_WIDTH + 1);
	// sum width for the saturating add, one bit above the wider operand
	localparam int SUM_WIDTH    = ((TOTAL_WIDTH > NUMBER_WIDTH) ? TOTAL_WIDTH : NUMBER_WIDTH) + 1;

	typedef struct packed {
		logic [NUMBER_WIDTH-1:0] number;
		logic                    clear_total;
	} in_t;

	typedef struct packed {
		logic [NUMBER_WIDTH-1:0] coprime_count;
		logic [TOTAL_WIDTH-1:0]  running_total;
	} out_t;

	// result of one gcd evaluation
	typedef struct packed {
		logic done;
		logic coprime;
	} gcd_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_COMMIT
	} top_state_t;

	typedef enum logic [1:0] {
		G_IDLE,
		G_TEST,
		G_DIV
	} gcd_state_t;

endpackage

@@ sv/tgc_rem.sv @@
// tgc_rem: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on tgc_pkg.
module tgc_rem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tgc_pkg::NUMBER_WIDTH-1:0] dividend,
	input  logic [tgc_pkg::NUMBER_WIDTH-1:0] divisor,
	output logic                             done,
	output logic [tgc_pkg::NUMBER_WIDTH-1:0] remainder
);
	import tgc_pkg::*;

	logic [NUMBER_WIDTH-1:0] dvd_q;
	logic [NUMBER_WIDTH-1:0] dvs_q;
	logic [NUMBER_WIDTH-1:0] rem_q;
	logic [STEP_WIDTH-1:0]   step_q;
	logic                    busy_q;
	logic                    done_q;
	logic [NUMBER_WIDTH:0]   trial;
	logic                    fits;

	// partial remainder stays below the divisor, so one extra bit holds the trial
	assign trial = {rem_q, dvd_q[NUMBER_WIDTH-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_WIDTH'(NUMBER_WIDTH);
			end else if (busy_q) begin
				step_q <= step_q - STEP_WIDTH'(1);
				if (step_q == STEP_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUMBER_WIDTH-2:0], 1'b0};
			rem_q <= fits ? NUMBER_WIDTH'(trial - {1'b0, dvs_q}) : trial[NUMBER_WIDTH-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ sv/tgc_gcd.sv @@
// tgc_gcd: Euclid sequencer, repeated remainder on the serial unit.
// Depends on tgc_pkg and tgc_rem.
module tgc_gcd (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tgc_pkg::NUMBER_WIDTH-1:0] a,
	input  logic [tgc_pkg::NUMBER_WIDTH-1:0] b,
	output tgc_pkg::gcd_stat_t               stat
);
	import tgc_pkg::*;

	gcd_state_t              state_q, state_d;
	logic [NUMBER_WIDTH-1:0] a_q;
	logic [NUMBER_WIDTH-1:0] b_q;
	logic                    rem_start;
	logic                    rem_done;
	logic [NUMBER_WIDTH-1:0] rem;
	logic                    b_zero;

	assign b_zero = (b_q == '0);

	tgc_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (a_q),
		.divisor   (b_q),
		.done      (rem_done),
		.remainder (rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			G_IDLE: if (start) state_d = G_TEST;
			G_TEST: state_d = b_zero ? G_IDLE : G_DIV;
			G_DIV:  if (rem_done) state_d = G_TEST;
			default: state_d = G_IDLE;
		endcase
	end

	always_comb begin
		rem_start    = (state_q == G_TEST) && !b_zero;
		stat.done    = (state_q == G_TEST) && b_zero;
		stat.coprime = (a_q == NUMBER_WIDTH'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == G_IDLE && start) begin
			a_q <= a;
			b_q <= b;
		end else if (state_q == G_DIV && rem_done) begin
			a_q <= b_q;
			b_q <= rem;
		end
	end

endmodule

@@ sv/totient_by_gcd_count.sv @@
// Operation: n of 0 or 1 goes straight to the result; otherwise gcd(n, i) is run for each i
// in 1..n-1 in turn, each through its remainder steps, bounded by the single bit-serial
// remainder unit (one bit per cycle).
// Throughput: one item at a time; a new item is taken while the last result waits.
// Reset: arst_n clears the running total, the control state and the output valid.
// Depends on tgc_pkg and tgc_gcd.
module totient_by_gcd_count (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tgc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tgc_pkg::out_t out_data
);
	import tgc_pkg::*;

	top_state_t              state_q, state_d;
	logic [NUMBER_WIDTH-1:0] n_q;
	logic [NUMBER_WIDTH-1:0] i_q;
	logic [NUMBER_WIDTH-1:0] count_q;
	logic                    clr_q;
	logic [TOTAL_WIDTH-1:0]  total_q;
	out_t                    out_q;
	logic                    out_valid_q;
	logic                    gcd_start;
	gcd_stat_t               gcd_stat;
	logic                    commit;
	logic                    last_i;
	logic                    small_n;
	logic [SUM_WIDTH-1:0]    sum;
	logic [TOTAL_WIDTH-1:0]  total_new;

	tgc_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (n_q),
		.b      (i_q),
		.stat   (gcd_stat)
	);

	assign small_n = (in_data.number <= NUMBER_WIDTH'(1));
	assign last_i  = (i_q == n_q - NUMBER_WIDTH'(1));

	// clear acts before this item's count goes in
	assign sum = SUM_WIDTH'(clr_q ? '0 : total_q) + SUM_WIDTH'(count_q);
	assign total_new = (sum[SUM_WIDTH-1:TOTAL_WIDTH] != '0) ? '1 : sum[TOTAL_WIDTH-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = small_n ? ST_COMMIT : ST_LAUNCH;
			ST_LAUNCH: state_d = ST_WAIT;
			ST_WAIT:   if (gcd_stat.done) state_d = last_i ? ST_COMMIT : ST_LAUNCH;
			ST_COMMIT: if (commit) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		gcd_start = (state_q == ST_LAUNCH);
		// output slot free or emptied by this transfer
		commit    = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				total_q     <= total_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			n_q     <= in_data.number;
			clr_q   <= in_data.clear_total;
			i_q     <= NUMBER_WIDTH'(1);
			count_q <= '0;
		end else if (state_q == ST_WAIT && gcd_stat.done) begin
			i_q <= i_q + NUMBER_WIDTH'(1);
			if (gcd_stat.coprime) begin
				count_q <= count_q + NUMBER_WIDTH'(1);
			end
		end
		if (commit) begin
			out_q.coprime_count <= count_q;
			out_q.running_total <= total_new;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/tgc_check.sv @@
// tgc_check: port-level checks for totient_by_gcd_count, bound to the top level.
// Depends on tgc_pkg.
module tgc_check (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input tgc_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input tgc_pkg::out_t out_data
);
	import tgc_pkg::*;

	// a waiting result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// one item at a time: busy right after an input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	// the total always includes this item's count
	a_total_covers_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.running_total >= TOTAL_WIDTH'(out_data.coprime_count))
		else $error("running total below this item's count");

	// count is at most n-1, never all ones
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.coprime_count != '1)
		else $error("coprime count out of range");

endmodule

bind totient_by_gcd_count tgc_check u_tgc_check (.*);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for totient_by_gcd_count; a small ledger class predicts the
// coprime count and saturating total of every accepted number and checks results in order.
// Depends on tgc_pkg and the totient_by_gcd_count RTL.
module tb_top;
	import tgc_pkg::*;

	class totient_ledger;
		out_t                   due_results[$];
		logic [TOTAL_WIDTH-1:0] total;
		int                     errors;
		int                     checked;
		int                     clears;
		int                     largest;

		function new();
			total   = '0;
			errors  = 0;
			checked = 0;
			clears  = 0;
			largest = 0;
		endfunction

		// brute-force count of i in 1..n-1 coprime to n, gcd by repeated remainder
		function logic [NUMBER_WIDTH-1:0] coprime_tally(input logic [NUMBER_WIDTH-1:0] n);
			logic [NUMBER_WIDTH-1:0] tally;
			logic [NUMBER_WIDTH-1:0] a;
			logic [NUMBER_WIDTH-1:0] b;
			logic [NUMBER_WIDTH-1:0] r;
			tally = '0;
			for (int i = 1; i < n; i++) begin
				a = n;
				b = NUMBER_WIDTH'(i);
				while (b != 0) begin
					r = a % b;
					a = b;
					b = r;
				end
				if (a == 1)
					tally++;
			end
			return tally;
		endfunction

		function void note_number(input in_t item);
			out_t                    due;
			logic [NUMBER_WIDTH-1:0] cnt;
			cnt = coprime_tally(item.number);
			if (item.clear_total) begin
				total = '0;
				clears++;
			end
			// headroom left below all ones is ~total
			if (TOTAL_WIDTH'(cnt) > ~total)
				total = '1;
			else
				total = total + TOTAL_WIDTH'(cnt);
			if (int'(item.number) > largest)
				largest = int'(item.number);
			due.coprime_count = cnt;
			due.running_total = total;
			due_results.push_back(due);
		endfunction

		function void check_result(input out_t got);
			out_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got count %0d total %0d",
					$time, got.coprime_count, got.running_total);
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (got.coprime_count !== want.coprime_count) begin
				errors++;
				$display("%0t: coprime_count mismatch: expected %0d, got %0d",
					$time, want.coprime_count, got.coprime_count);
			end
			if (got.running_total !== want.running_total) begin
				errors++;
				$display("%0t: running_total mismatch: expected %0d, got %0d",
					$time, want.running_total, got.running_total);
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	totient_ledger ledger = new();

	// calm: no idling on either side; hold_request: receiver takes one long stall
	bit calm         = 1'b0;
	bit hold_request = 1'b0;
	int sent         = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	totient_by_gcd_count u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// returns at the edge of the transfer with in_valid still high, so a following
	// call can present the next number without a bubble
	task automatic offer_number(input logic [NUMBER_WIDTH-1:0] n, input logic clr);
		in_t item;
		int  gap;
		item.number      = n;
		item.clear_total = clr;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ledger.note_number(item);
		sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		in_valid <= 1'b0;
		in_data  <= '0;
		arst_n   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero and one give no count and leave the total alone
		offer_number(0, 1'b0);
		offer_number(1, 1'b0);
		offer_number(2, 1'b0);
		offer_number(3, 1'b0);
		offer_number(4, 1'b0);
		offer_number(5, 1'b0);
		offer_number(6, 1'b0);
		offer_number(7, 1'b0);
		offer_number(12, 1'b0);
		offer_number(13, 1'b0);
		offer_number(64, 1'b0);
		offer_number(97, 1'b0);
		offer_number(128, 1'b0);
		offer_number(255, 1'b0);
		// clear acts before the add, also with a zero count
		offer_number(10, 1'b1);
		offer_number(0, 1'b1);
		offer_number(1, 1'b0);
		offer_number(30, 1'b0);
		offer_number(4, 1'b1);
		// widest number: every bit set, by far the longest item of the run
		offer_number('1, 1'b1);
		offer_number(1023, 1'b0);
		// saturation of the total is out of reach: it takes billions of items

		// sender waits for the block to run dry
		drain_results();

		// long receiver stall while numbers keep coming, so the block fills up
		calm         = 1'b1;
		hold_request = 1'b1;
		for (int k = 0; k < 8; k++)
			offer_number(NUMBER_WIDTH'(k % 4), 1'b0);
		calm = 1'b0;

		for (int k = 0; k < 70; k++) begin
			calm = (k >= 40 && k < 60);
			offer_number(NUMBER_WIDTH'(($urandom_range(0, 15) == 0) ? $urandom_range(128, 1023)
				: $urandom_range(0, 127)), $urandom_range(0, 7) == 0);
		end
		calm = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		$display("%0d numbers sent (largest %0d, %0d with a total clear), %0d results checked",
			sent, ledger.largest, ledger.clears, ledger.checked);
		$display("directed small and prime values, full-width number, clears, a long output stall");
		if (ledger.errors == 0)
			$display("totient_by_gcd_count verification clean");
		else
			$display("totient_by_gcd_count verification failed");
		$finish;
	end

	initial begin : result_sink
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) begin
				if (hold_request) begin
					hold_request = 1'b0;
					out_ready <= 1'b0;
					repeat (400) @(posedge clk);
					out_ready <= 1'b1;
				end
				@(posedge clk);
			end
			ledger.check_result(out_data);
		end
	end

	// the full-width number alone dominates the run time
	initial begin : watchdog
		#300000000;
		$display("totient_by_gcd_count verification failed");
		$finish;
	end

endmodule
